/* src/nrsf_pkg.sv */
// shared types, constants and helpers for the newline record substring filter
// no dependencies
package nrsf_pkg;

	localparam logic [7:0] NEWLINE_BYTE = 8'd10;
	localparam int unsigned KEY_WIDTH = 64;
	localparam int unsigned KEY_LEN_WIDTH = 4;
	localparam int unsigned MIN_LEN_WIDTH = 16;
	localparam int unsigned CNT_WIDTH = 32;
	localparam int unsigned REG_INDEX_WIDTH = 2;
	localparam logic [CNT_WIDTH-1:0] CNT_MAX = '1;

	typedef enum logic [REG_INDEX_WIDTH-1:0] {
		REG_KEY_BYTES = 2'd0,
		REG_KEY_LENGTH = 2'd1,
		REG_MIN_RECORD_LENGTH = 2'd2
	} reg_index_t;

	// live configuration as seen by the datapath
	typedef struct packed {
		logic [KEY_WIDTH-1:0] key;
		logic [KEY_LEN_WIDTH-1:0] key_len;
		logic [MIN_LEN_WIDTH-1:0] min_len;
	} cfg_t;

	// one step of the record datapath
	typedef struct packed {
		logic advance;
		logic is_newline;
		logic [7:0] data;
	} step_t;

	function automatic logic [CNT_WIDTH-1:0] sat_inc(input logic [CNT_WIDTH-1:0] v);
		sat_inc = (v == CNT_MAX) ? CNT_MAX : v + CNT_WIDTH'(1);
	endfunction

endpackage

/* src/nrsf_if.sv */
// handshake channels: text bytes in, matching records out
// depends on nrsf_pkg for field widths
interface nrsf_byte_if;
	logic valid;
	logic ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface nrsf_rec_if;
	logic valid;
	logic ready;
	logic [nrsf_pkg::CNT_WIDTH-1:0] record_offset;
	logic [nrsf_pkg::CNT_WIDTH-1:0] record_size;

	modport source (output valid, output record_offset, output record_size, input ready);
	modport sink (input valid, input record_offset, input record_size, output ready);
endinterface

/* src/nrsf_cfg.sv */
// configuration registers and effective key length clamp
// depends on nrsf_pkg
module nrsf_cfg #(
	parameter int unsigned MAX_KEY_BYTES = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  logic [nrsf_pkg::REG_INDEX_WIDTH-1:0] wr_index,
	input  logic [nrsf_pkg::KEY_WIDTH-1:0] wr_data,
	output nrsf_pkg::cfg_t cfg
);

	localparam logic [nrsf_pkg::KEY_LEN_WIDTH-1:0] MAX_LEN =
		nrsf_pkg::KEY_LEN_WIDTH'(MAX_KEY_BYTES);

	logic [nrsf_pkg::KEY_WIDTH-1:0] key_q;
	logic [nrsf_pkg::KEY_LEN_WIDTH-1:0] key_len_q;
	logic [nrsf_pkg::MIN_LEN_WIDTH-1:0] min_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
			key_len_q <= '0;
			min_len_q <= nrsf_pkg::MIN_LEN_WIDTH'(8);
		end else if (wr_en) begin
			case (nrsf_pkg::reg_index_t'(wr_index))
				nrsf_pkg::REG_KEY_BYTES: key_q <= wr_data;
				nrsf_pkg::REG_KEY_LENGTH: key_len_q <= wr_data[nrsf_pkg::KEY_LEN_WIDTH-1:0];
				nrsf_pkg::REG_MIN_RECORD_LENGTH:
					min_len_q <= wr_data[nrsf_pkg::MIN_LEN_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.key = key_q;
		cfg.key_len = (key_len_q > MAX_LEN) ? MAX_LEN : key_len_q;
		cfg.min_len = min_len_q;
	end

endmodule

/* src/nrsf_window.sv */
// window of the most recent record bytes and parallel key compare
// depends on nrsf_pkg
module nrsf_window #(
	parameter int unsigned MAX_KEY_BYTES = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  nrsf_pkg::step_t step,
	input  logic [nrsf_pkg::KEY_WIDTH-1:0] key,
	input  logic [nrsf_pkg::KEY_LEN_WIDTH-1:0] key_len,
	output logic hit
);

	logic [7:0] win_q [MAX_KEY_BYTES];
	logic [7:0] win_next [MAX_KEY_BYTES];

	// entry 0 is the newest byte
	always_comb begin
		win_next[0] = step.data;
		for (int i = 1; i < MAX_KEY_BYTES; i++) begin
			win_next[i] = win_q[i-1];
		end
	end

	// compares the window as it stands after this byte
	always_comb begin
		hit = 1'b1;
		for (int i = 0; i < MAX_KEY_BYTES; i++) begin
			if ((nrsf_pkg::KEY_LEN_WIDTH'(i) < key_len) && (win_next[i] != key[8*i +: 8])) begin
				hit = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_KEY_BYTES; i++) begin
				win_q[i] <= '0;
			end
		end else if (step.advance) begin
			for (int i = 0; i < MAX_KEY_BYTES; i++) begin
				win_q[i] <= step.is_newline ? 8'd0 : win_next[i];
			end
		end
	end

endmodule

/* src/nrsf_outreg.sv */
// result register that holds one record word until the sink takes it
// depends on nrsf_pkg and nrsf_rec_if
module nrsf_outreg (
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  logic [nrsf_pkg::CNT_WIDTH-1:0] offset,
	input  logic [nrsf_pkg::CNT_WIDTH-1:0] length,
	output logic free,
	nrsf_rec_if.source records
);

	logic valid_q;
	logic [nrsf_pkg::CNT_WIDTH-1:0] offset_q;
	logic [nrsf_pkg::CNT_WIDTH-1:0] length_q;

	assign free = !valid_q || records.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			offset_q <= offset;
			length_q <= length;
		end
	end

	assign records.valid = valid_q;
	assign records.record_offset = offset_q;
	assign records.record_size = length_q;

endmodule

/* src/newline_record_substring_filter_core.sv */
// top level of the newline record substring filter
// depends on nrsf_pkg, nrsf_if, nrsf_cfg, nrsf_window, nrsf_outreg

// Takes one text byte per cycle and splits the stream into records at newline bytes. An
// accepted byte lands in an input register; from there a single stage shifts it into
// the key window, compares up to MAX_KEY_BYTES bytes in parallel against the key, updates the
// saturating record counters and, on a newline that closes a qualifying record, loads the
// record word into the result register. Throughput is one byte per cycle; a newline passes
// the input register, then its word the result register. The input stalls only when a new
// word is due while the previous word still waits there. The user writes configuration
// through wr_en/wr_index/wr_data only while the block is idle; the block does not enforce it.
module newline_record_substring_filter_core #(
	parameter int unsigned MAX_KEY_BYTES = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  logic [nrsf_pkg::REG_INDEX_WIDTH-1:0] wr_index,
	input  logic [nrsf_pkg::KEY_WIDTH-1:0] wr_data,
	nrsf_byte_if.sink text,
	nrsf_rec_if.source records
);

	nrsf_pkg::cfg_t cfg;
	nrsf_pkg::step_t step;

	logic valid_s1;
	logic [7:0] byte_s1;
	logic [nrsf_pkg::CNT_WIDTH-1:0] bir_q;
	logic [nrsf_pkg::CNT_WIDTH-1:0] pos_q;
	logic [nrsf_pkg::CNT_WIDTH-1:0] start_q;
	logic key_seen_q;
	logic [nrsf_pkg::CNT_WIDTH-1:0] bir_inc;
	logic win_hit;
	logic emit;
	logic out_free;
	logic is_newline;

	nrsf_cfg #(.MAX_KEY_BYTES(MAX_KEY_BYTES)) u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.cfg(cfg)
	);

	assign is_newline = (byte_s1 == nrsf_pkg::NEWLINE_BYTE);
	assign bir_inc = nrsf_pkg::sat_inc(bir_q);
	assign emit = valid_s1 && is_newline
		&& (bir_q > {{(nrsf_pkg::CNT_WIDTH-nrsf_pkg::MIN_LEN_WIDTH){1'b0}}, cfg.min_len})
		&& ((cfg.key_len == '0) || key_seen_q);

	always_comb begin
		step.advance = valid_s1 && (!emit || out_free);
		step.is_newline = is_newline;
		step.data = byte_s1;
	end

	assign text.ready = !valid_s1 || step.advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			byte_s1 <= text.data_byte;
		end
	end

	nrsf_window #(.MAX_KEY_BYTES(MAX_KEY_BYTES)) u_window (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.key(cfg.key),
		.key_len(cfg.key_len),
		.hit(win_hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bir_q <= '0;
			pos_q <= '0;
			start_q <= '0;
			key_seen_q <= 1'b0;
		end else if (step.advance) begin
			pos_q <= nrsf_pkg::sat_inc(pos_q);
			if (is_newline) begin
				bir_q <= '0;
				key_seen_q <= 1'b0;
				start_q <= nrsf_pkg::sat_inc(pos_q);
			end else begin
				bir_q <= bir_inc;
				// the window only holds record bytes once the record is long enough
				if ((cfg.key_len != '0) && win_hit
						&& (bir_inc >= {{(nrsf_pkg::CNT_WIDTH-nrsf_pkg::KEY_LEN_WIDTH){1'b0}},
						cfg.key_len})) begin
					key_seen_q <= 1'b1;
				end
			end
		end
	end

	nrsf_outreg u_outreg (
		.clk(clk),
		.arst_n(arst_n),
		.load(emit && out_free),
		.offset(start_q),
		.length(bir_q),
		.free(out_free),
		.records(records)
	);

`ifndef ASSERT_OFF
	a_start_not_ahead: assert property (@(posedge clk) disable iff (!arst_n)
		start_q <= pos_q)
		else $error("record start ahead of stream position");

	a_seen_needs_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		key_seen_q |-> (bir_q != '0))
		else $error("key seen in an empty record");

	a_newline_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(step.advance && is_newline) |=> ((bir_q == '0) && !key_seen_q))
		else $error("record state not cleared after newline");

	a_word_qualifies: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && out_free) |=> (records.valid
			&& (records.record_size
				> {{(nrsf_pkg::CNT_WIDTH-nrsf_pkg::MIN_LEN_WIDTH){1'b0}}, cfg.min_len})))
		else $error("record word too short");

	a_stall_only_on_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !step.advance) |-> (emit && records.valid))
		else $error("input stalled without a pending record word");
`endif

endmodule

/* tb/nrsf_record_checker.sv */
// record checker for the newline record substring filter: watches the byte and record
// channels and the register port, predicts every record word and compares it
// depends on nrsf_pkg and nrsf_if
`timescale 1ns / 1ps

module nrsf_record_checker #(
	parameter int unsigned MAX_KEY_BYTES = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  logic [nrsf_pkg::REG_INDEX_WIDTH-1:0] wr_index,
	input  logic [nrsf_pkg::KEY_WIDTH-1:0] wr_data,
	nrsf_byte_if text,
	nrsf_rec_if records,
	output int unsigned mismatches,
	output int unsigned words_due
);

	typedef struct packed {
		logic [nrsf_pkg::CNT_WIDTH-1:0] offset;
		logic [nrsf_pkg::CNT_WIDTH-1:0] length;
	} rec_word_t;

	rec_word_t due_words[$];
	rec_word_t want;
	int unsigned fail_count = 0;
	int unsigned due_count = 0;

	logic [nrsf_pkg::KEY_WIDTH-1:0] key;
	logic [nrsf_pkg::KEY_LEN_WIDTH-1:0] key_len;
	logic [nrsf_pkg::MIN_LEN_WIDTH-1:0] min_len;
	logic [7:0] window [MAX_KEY_BYTES];
	logic [nrsf_pkg::CNT_WIDTH-1:0] rec_len;
	logic [nrsf_pkg::CNT_WIDTH-1:0] position;
	logic [nrsf_pkg::CNT_WIDTH-1:0] rec_start;
	logic key_hit;

	assign mismatches = fail_count;
	assign words_due = due_count;

	function automatic logic [nrsf_pkg::CNT_WIDTH-1:0] saturated_next(
			input logic [nrsf_pkg::CNT_WIDTH-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t: mismatch: %s", $time, msg);
		fail_count++;
	endtask

	// one accepted text byte: update the record state, queue a word on a qualifying newline
	task automatic take_byte(input logic [7:0] b);
		int unsigned n;
		bit hit;
		n = (key_len > MAX_KEY_BYTES) ? MAX_KEY_BYTES : key_len;
		if (b == nrsf_pkg::NEWLINE_BYTE) begin
			if (rec_len > min_len && (n == 0 || key_hit))
				due_words.push_back('{offset: rec_start, length: rec_len});
			for (int i = 0; i < MAX_KEY_BYTES; i++)
				window[i] = '0;
			rec_len = '0;
			key_hit = 1'b0;
			rec_start = saturated_next(position);
		end else begin
			for (int i = MAX_KEY_BYTES - 1; i > 0; i--)
				window[i] = window[i-1];
			window[0] = b;
			rec_len = saturated_next(rec_len);
			if (n > 0 && rec_len >= n) begin
				// newest byte against the last key byte, older bytes against earlier ones
				hit = 1'b1;
				for (int i = 0; i < n; i++)
					if (window[i] != key[8*i +: 8])
						hit = 1'b0;
				if (hit)
					key_hit = 1'b1;
			end
		end
		position = saturated_next(position);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key = '0;
			key_len = '0;
			min_len = nrsf_pkg::MIN_LEN_WIDTH'(8);
			for (int i = 0; i < MAX_KEY_BYTES; i++)
				window[i] = '0;
			rec_len = '0;
			position = '0;
			rec_start = '0;
			key_hit = 1'b0;
			due_words.delete();
			due_count = 0;
		end else begin
			if (records.valid && records.ready) begin
				if (due_words.size() == 0) begin
					report_mismatch($sformatf("unexpected word offset %0d size %0d",
						records.record_offset, records.record_size));
				end else begin
					want = due_words.pop_front();
					if (records.record_offset !== want.offset)
						report_mismatch($sformatf("record_offset got %0d expected %0d",
							records.record_offset, want.offset));
					if (records.record_size !== want.length)
						report_mismatch($sformatf("record_size got %0d expected %0d",
							records.record_size, want.length));
				end
			end
			if (wr_en) begin
				case (nrsf_pkg::reg_index_t'(wr_index))
					nrsf_pkg::REG_KEY_BYTES: key = wr_data;
					nrsf_pkg::REG_KEY_LENGTH:
						key_len = wr_data[nrsf_pkg::KEY_LEN_WIDTH-1:0];
					nrsf_pkg::REG_MIN_RECORD_LENGTH:
						min_len = wr_data[nrsf_pkg::MIN_LEN_WIDTH-1:0];
					default: ;
				endcase
			end
			if (text.valid && text.ready)
				take_byte(text.data_byte);
			due_count = due_words.size();
		end
	end

endmodule

/* tb/newline_record_substring_filter_core_tb.sv */
// testbench top for the newline record substring filter: reset, register writes,
// directed records, then random keyed records with idling on both channels
// depends on nrsf_pkg, nrsf_if, the filter core and nrsf_record_checker
`timescale 1ns / 1ps

module newline_record_substring_filter_core_tb;

	localparam int unsigned DRAIN_CYCLES = 6;
	localparam int unsigned PHASES = 8;
	localparam int unsigned BYTES_PER_PHASE = 212;

	logic clk = 1'b0;
	logic arst_n;
	logic wr_en;
	logic [nrsf_pkg::REG_INDEX_WIDTH-1:0] wr_index;
	logic [nrsf_pkg::KEY_WIDTH-1:0] wr_data;
	bit steady = 1'b0;
	int unsigned bytes_sent = 0;
	int unsigned mismatches;
	int unsigned words_due;

	nrsf_byte_if text_ch();
	nrsf_rec_if rec_ch();

	newline_record_substring_filter_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.text(text_ch),
		.records(rec_ch)
	);

	nrsf_record_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.text(text_ch),
		.records(rec_ch),
		.mismatches(mismatches),
		.words_due(words_due)
	);

	always #4 clk = ~clk;

	initial begin
		#5000000;
		$display("TEST FAILED");
		$finish;
	end

	// called and returning at a falling edge
	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		gap = (steady || $urandom_range(0, 1)) ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			text_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		text_ch.valid <= 1'b1;
		text_ch.data_byte <= b;
		@(posedge clk);
		while (!text_ch.ready)
			@(posedge clk);
		bytes_sent++;
		@(negedge clk);
	endtask

	// hold the input until every word is out, then let the pipeline empty
	task automatic settle();
		text_ch.valid <= 1'b0;
		while (words_due != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic configure(input logic [nrsf_pkg::KEY_WIDTH-1:0] key, input logic [3:0] len,
			input logic [15:0] min_len);
		logic [63:0] junk;
		junk = {$urandom, $urandom};
		wr_en <= 1'b1;
		wr_index <= nrsf_pkg::REG_KEY_BYTES;
		wr_data <= key;
		@(negedge clk);
		wr_index <= nrsf_pkg::REG_KEY_LENGTH;
		wr_data <= {junk[63:4], len};
		@(negedge clk);
		wr_index <= nrsf_pkg::REG_MIN_RECORD_LENGTH;
		wr_data <= {junk[63:16], min_len};
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	function automatic logic [7:0] pick_byte(input logic [nrsf_pkg::KEY_WIDTH-1:0] key);
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return key[8*$urandom_range(0, 7) +: 8];
			5: return "a";
			6: return 8'h00;
			7: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [nrsf_pkg::KEY_WIDTH-1:0] make_key();
		logic [nrsf_pkg::KEY_WIDTH-1:0] k;
		for (int i = 0; i < 8; i++)
			case ($urandom_range(0, 4))
				0: k[8*i +: 8] = 8'h00;
				1: k[8*i +: 8] = 8'hFF;
				2, 3: k[8*i +: 8] = 8'("a" + $urandom_range(0, 2));
				default: k[8*i +: 8] = 8'($urandom_range(0, 255));
			endcase
		return k;
	endfunction

	// random body with a full key, a key missing its last byte, or no key
	task automatic send_record(input logic [nrsf_pkg::KEY_WIDTH-1:0] key, input int unsigned n,
			input bit terminate);
		int unsigned body, at, kind, used;
		body = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 16);
		at = $urandom_range(0, body);
		kind = $urandom_range(0, 9);
		used = (kind < 6) ? n : (kind < 8 && n > 0) ? n - 1 : 0;
		for (int i = 0; i <= body; i++) begin
			if (i == at)
				for (int j = 0; j < used; j++)
					send_byte(key[8*(n-1-j) +: 8]);
			if (i < body)
				send_byte(pick_byte(key));
		end
		if (terminate)
			send_byte(nrsf_pkg::NEWLINE_BYTE);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	initial begin
		int unsigned target;
		rec_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			target = steady ? 0 : $urandom_range(0, 17);
			if (target > 0) begin
				rec_ch.ready <= 1'b0;
				repeat (target) @(negedge clk);
			end
			rec_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rec_ch.valid)
				@(posedge clk);
			@(negedge clk);
		end
	end

	initial begin
		int unsigned target;
		logic [nrsf_pkg::KEY_WIDTH-1:0] key;
		logic [3:0] len;
		logic [15:0] min_len;
		text_ch.valid = 1'b0;
		text_ch.data_byte = '0;
		wr_en = 1'b0;
		wr_index = nrsf_pkg::REG_KEY_BYTES;
		wr_data = '0;
		arst_n = 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: empty key, records longer than 8 pass, zero bytes are data
		send_byte(8'h00);
		send_byte(8'hFF);
		send_text("abcdefg\n\n");
		settle();
		// two byte key must not match across a newline
		configure(64'hC3A5_5A3C_9E01_4142, 4'd2, 16'd0);
		send_text("A\nB\nAB\n");
		settle();
		// oversized key length acts as eight bytes
		configure(64'h0001_0203_0405_0607, 4'd12, 16'd7);
		for (int i = 0; i < 8; i++)
			send_byte(8'(i));
		send_byte(nrsf_pkg::NEWLINE_BYTE);

		for (int p = 0; p < PHASES; p++) begin
			settle();
			key = make_key();
			case (p)
				0: begin len = 4'd0; min_len = 16'd0; end
				1: begin len = 4'd8; min_len = 16'd3; end
				2: begin len = 4'd1; min_len = 16'hFFFF; end
				3: begin len = 4'd15; min_len = 16'd0; end
				default: begin
					len = 4'($urandom_range(0, 15));
					min_len = 16'($urandom_range(0, 12));
				end
			endcase
			configure(key, len, min_len);
			steady = (p % 3 == 1);
			target = bytes_sent + BYTES_PER_PHASE;
			while (bytes_sent < target)
				send_record(key, (len > 8) ? 8 : len, 1'b1);
			// sometimes leave a record open so the next key lands mid-record
			if ($urandom_range(0, 2) == 0)
				send_record(key, (len > 8) ? 8 : len, 1'b0);
		end
		send_byte(nrsf_pkg::NEWLINE_BYTE);
		steady = 1'b0;
		settle();
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

/* files.f */
src/nrsf_pkg.sv
src/nrsf_if.sv
src/nrsf_cfg.sv
src/nrsf_window.sv
src/nrsf_outreg.sv
src/newline_record_substring_filter_core.sv
tb/nrsf_record_checker.sv
tb/newline_record_substring_filter_core_tb.sv
